### src/aepd_pkg.sv
// aepd_pkg: shared types and constants for the auto-exposure pd / latency test unit
// no dependencies; imported by aepd_ctrl, aepd_datapath and the top level
package aepd_pkg;

  localparam int unsigned MeanW   = 15;
  localparam int unsigned GainW   = 16;
  localparam int unsigned ExpW    = 32;
  localparam int unsigned LatW    = 13;
  localparam int unsigned SettleW = 5;
  localparam int unsigned RoundW  = 2;
  localparam int unsigned CountW  = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;

  // latency divider: dividend is count*avg + settle*256, divisor is count+1
  localparam int unsigned DivW    = 30;
  localparam int unsigned DsrW    = 17;
  localparam int unsigned DivCntW = 5;
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivW - 1);

  localparam logic [SettleW-1:0] QuietFrames   = SettleW'(3);
  localparam logic [SettleW-1:0] TimeoutFrames = SettleW'(20);
  localparam logic [RoundW:0]    InitRounds    = (RoundW + 1)'(2);
  localparam logic [ExpW-1:0]    ExposureReset = ExpW'(10000);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegTestMode  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegTarget    = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegPropGain  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegDiffGain  = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] RegExpLow    = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] RegExpHigh   = CfgIdxW'(5);

  typedef enum logic [2:0] {
    PH_INIT        = 3'd0,
    PH_INIT_DARK   = 3'd1,
    PH_INIT_BRIGHT = 3'd2,
    PH_MEAS_DARK   = 3'd3,
    PH_MEAS_BRIGHT = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_COMMIT
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic mul;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } status_t;

endpackage

### src/aepd_ctrl.sv
// aepd_ctrl: sequencer for one frame: capture, multiply, optional divide, commit
// depends on aepd_pkg
module aepd_ctrl
  import aepd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = status_i.need_div ? ST_DIV : ST_COMMIT;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + DivCntW'(1);
        if (cnt_q == DivLast) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // hold until the output register can take the result
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### src/aepd_datapath.sv
// aepd_datapath: config registers, control/test state, multipliers, serial divider
// and the output register; depends on aepd_pkg, driven by aepd_ctrl
module aepd_datapath
  import aepd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic [MeanW-1:0]   frame_mean_i,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ExpW-1:0]    exposure_out_o,
  output logic               exposure_write_o,
  output logic [LatW-1:0]    latency_avg_o,
  output logic               latency_update_o
);

  // configuration
  logic                test_mode_q;
  logic [MeanW-1:0]    target_q;
  logic [GainW-1:0]    prop_gain_q, diff_gain_q;
  logic [ExpW-1:0]     exp_low_q, exp_high_q;

  // block state
  phase_e              phase_q, phase_d;
  logic [ExpW-1:0]     exp_acc_q, exp_acc_d;
  logic [MeanW-1:0]    last_q, last_d;
  logic [SettleW-1:0]  settle_q, settle_d;
  logic [RoundW-1:0]   rounds_q, rounds_d;
  logic [CountW-1:0]   mcount_q, mcount_d;
  logic [MeanW-1:0]    dark_q, dark_d, bright_q, bright_d;
  logic [LatW-1:0]     lat_q, lat_d;

  // per-frame working registers
  logic [MeanW-1:0]    mean_q;
  logic signed [ExpW-1:0] p_q, d_q;
  logic [DivW-1:0]     quo_q;
  logic [DsrW-1:0]     rem_q;

  // output register
  logic                out_valid_q;
  logic [ExpW-1:0]     exp_out_q;
  logic                exp_wr_q;
  logic [LatW-1:0]     lat_out_q;
  logic                lat_upd_q;

  // next values at commit
  logic [ExpW-1:0]     exp_out_d;
  logic                exp_wr_d;
  logic                lat_upd_d;

  // ---------------------------------------------------------------- near test
  logic [MeanW-1:0]    ref_mean, diff_abs;
  logic [MeanW+3:0]    diff_x10;
  logic [MeanW:0]      ref_plus;
  logic                is_meas, near;

  always_comb begin
    is_meas  = (phase_q == PH_MEAS_DARK) || (phase_q == PH_MEAS_BRIGHT);
    ref_mean = (phase_q == PH_MEAS_DARK) ? dark_q : bright_q;
    diff_abs = (mean_q > ref_mean) ? (mean_q - ref_mean) : (ref_mean - mean_q);
    diff_x10 = ({4'b0, diff_abs} << 3) + ({4'b0, diff_abs} << 1);
    ref_plus = {1'b0, ref_mean} + (MeanW + 1)'(10);
    near     = diff_x10 < {3'b0, ref_plus};
  end

  assign status_o.need_div = test_mode_q && is_meas && near;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // ---------------------------------------------------------------- multiply operands
  logic [MeanW-1:0]        last_eff;
  logic signed [GainW-1:0] err_p, err_d;
  logic [DivW-1:0]         lat_num;
  logic [DsrW-1:0]         divisor;

  always_comb begin
    // the first frame seeds last_mean so its derivative term is zero
    last_eff = (last_q == '0) ? mean_q : last_q;
    err_p    = $signed({1'b0, target_q} - {1'b0, mean_q});
    err_d    = $signed({1'b0, mean_q} - {1'b0, last_eff});
    lat_num  = DivW'(mcount_q) * DivW'(lat_q) + DivW'({settle_q, 8'b0});
    divisor  = {1'b0, mcount_q} + DsrW'(1);
  end

  // ---------------------------------------------------------------- divider step
  logic [DsrW:0] div_shift, div_trial;

  always_comb begin
    div_shift = {rem_q, quo_q[DivW-1]};
    div_trial = div_shift - {1'b0, divisor};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mean_q <= frame_mean_i;
    end
    if (cmd_i.mul) begin
      p_q   <= ExpW'(err_p) * ExpW'($signed(prop_gain_q));
      d_q   <= ExpW'(err_d) * ExpW'($signed(diff_gain_q));
      quo_q <= lat_num;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (!div_trial[DsrW]) begin
        rem_q <= div_trial[DsrW-1:0];
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= div_shift[DsrW-1:0];
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
    end
  end

  // ---------------------------------------------------------------- commit logic
  logic [SettleW-1:0] settle_inc;
  logic [RoundW:0]    rounds_inc;

  always_comb begin
    settle_inc = settle_q + SettleW'(1);
    rounds_inc = {1'b0, rounds_q} + (RoundW + 1)'(1);
    phase_d    = phase_q;
    exp_acc_d  = exp_acc_q;
    last_d     = last_q;
    settle_d   = settle_q;
    rounds_d   = rounds_q;
    mcount_d   = mcount_q;
    dark_d     = dark_q;
    bright_d   = bright_q;
    lat_d      = lat_q;
    exp_out_d  = '0;
    exp_wr_d   = 1'b0;
    lat_upd_d  = 1'b0;

    if (!test_mode_q) begin
      exp_acc_d = exp_acc_q + ExpW'(p_q) + ExpW'(d_q);
      last_d    = mean_q;
      exp_out_d = exp_acc_d;
      exp_wr_d  = 1'b1;
    end else begin
      unique case (phase_q) inside
        PH_INIT_DARK: begin
          if (mean_q < dark_q) begin
            dark_d   = mean_q;
            settle_d = '0;
          end else begin
            settle_d = settle_inc;
          end
          if (settle_d == QuietFrames) begin
            settle_d  = '0;
            bright_d  = mean_q;
            exp_out_d = exp_high_q;
            exp_wr_d  = 1'b1;
            phase_d   = PH_INIT_BRIGHT;
          end
        end
        PH_INIT_BRIGHT: begin
          if (mean_q > bright_q) begin
            bright_d = mean_q;
            settle_d = '0;
          end else begin
            settle_d = settle_inc;
          end
          if (settle_d == QuietFrames) begin
            settle_d  = '0;
            exp_out_d = exp_low_q;
            exp_wr_d  = 1'b1;
            rounds_d  = rounds_inc[RoundW-1:0];
            if (rounds_inc < InitRounds) begin
              dark_d  = mean_q;
              phase_d = PH_INIT_DARK;
            end else begin
              phase_d = PH_MEAS_DARK;
            end
          end
        end
        PH_MEAS_DARK, PH_MEAS_BRIGHT: begin
          if (near) begin
            lat_d     = quo_q[LatW-1:0];
            mcount_d  = (mcount_q == '1) ? mcount_q : mcount_q + CountW'(1);
            lat_upd_d = 1'b1;
            settle_d  = '0;
            exp_out_d = (phase_q == PH_MEAS_DARK) ? exp_high_q : exp_low_q;
            exp_wr_d  = 1'b1;
            phase_d   = (phase_q == PH_MEAS_DARK) ? PH_MEAS_BRIGHT : PH_MEAS_DARK;
          end else begin
            settle_d = settle_inc;
          end
        end
        default: begin
          // restart the test: learn both extremes from scratch
          rounds_d  = '0;
          settle_d  = '0;
          mcount_d  = '0;
          dark_d    = mean_q;
          bright_d  = mean_q;
          exp_out_d = exp_high_q;
          exp_wr_d  = 1'b1;
          phase_d   = PH_INIT_BRIGHT;
        end
      endcase
      if (settle_d > TimeoutFrames) begin
        phase_d = PH_INIT;
      end
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      test_mode_q <= 1'b0;
      target_q    <= MeanW'(100);
      prop_gain_q <= GainW'(1);
      diff_gain_q <= '0;
      exp_low_q   <= '0;
      exp_high_q  <= ExposureReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegTestMode: test_mode_q <= cfg_wdata_i[0];
        RegTarget:   target_q    <= cfg_wdata_i[MeanW-1:0];
        RegPropGain: prop_gain_q <= cfg_wdata_i[GainW-1:0];
        RegDiffGain: diff_gain_q <= cfg_wdata_i[GainW-1:0];
        RegExpLow:   exp_low_q   <= cfg_wdata_i[ExpW-1:0];
        RegExpHigh:  exp_high_q  <= cfg_wdata_i[ExpW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_INIT;
      exp_acc_q <= ExposureReset;
      last_q    <= '0;
      settle_q  <= '0;
      rounds_q  <= '0;
      mcount_q  <= '0;
      dark_q    <= '0;
      bright_q  <= '0;
      lat_q     <= '0;
    end else if (cmd_i.commit) begin
      phase_q   <= phase_d;
      exp_acc_q <= exp_acc_d;
      last_q    <= last_d;
      settle_q  <= settle_d;
      rounds_q  <= rounds_d;
      mcount_q  <= mcount_d;
      dark_q    <= dark_d;
      bright_q  <= bright_d;
      lat_q     <= lat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      exp_out_q <= exp_out_d;
      exp_wr_q  <= exp_wr_d;
      lat_out_q <= lat_d;
      lat_upd_q <= lat_upd_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign exposure_out_o   = exp_out_q;
  assign exposure_write_o = exp_wr_q;
  assign latency_avg_o    = lat_out_q;
  assign latency_update_o = lat_upd_q;

endmodule

### src/auto_exposure_pd_latency_test_unit.sv
// auto_exposure_pd_latency_test_unit: top level, pd exposure control and latency test
// depends on aepd_pkg, aepd_ctrl and aepd_datapath
//
//   channel | handshake                 | payload
//   --------+---------------------------+----------------------------------------------
//   in      | in_valid_i / in_ready_o   | frame_mean_i
//   out     | out_valid_o / out_ready_i | exposure_out_o, exposure_write_o,
//           |                           | latency_avg_o, latency_update_o
//   cfg     | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// a transaction runs capture, multiply and commit; when the latency average
// is folded in, the 30-step restoring divider runs between multiply and commit
// in_ready_o is high only while the sequencer is idle; one frame is in work at a time
// a finished result sits in the output register, so the next frame can start while it waits
// if the output register is still full at commit time the sequencer holds there
// reset loads the register defaults and clears all test state; no clearing pass
module auto_exposure_pd_latency_test_unit
  import aepd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [MeanW-1:0]   frame_mean_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ExpW-1:0]    exposure_out_o,
  output logic               exposure_write_o,
  output logic [LatW-1:0]    latency_avg_o,
  output logic               latency_update_o
);

  cmd_t    cmd;
  status_t status;

  aepd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  aepd_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .frame_mean_i     (frame_mean_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .exposure_out_o   (exposure_out_o),
    .exposure_write_o (exposure_write_o),
    .latency_avg_o    (latency_avg_o),
    .latency_update_o (latency_update_o)
  );

endmodule

### test/tb_auto_exposure_pd_latency_test_unit.sv
`timescale 1ns / 100ps
// tb_auto_exposure_pd_latency_test_unit: self-checking bench for the pd exposure / latency unit
// drives a directed table and random frame segments; checks known rows against the table, predicts the rest in-bench
// depends on aepd_pkg and auto_exposure_pd_latency_test_unit
module tb_auto_exposure_pd_latency_test_unit;
  import aepd_pkg::*;

  localparam int unsigned NumDirected  = 34;
  localparam int unsigned RandomFrames = 1325;
  localparam int unsigned DrainCycles  = 40;
  localparam int unsigned RxHoldCycles = 300;
  localparam int unsigned IdleLimit    = 4000;

  typedef struct packed {
    logic [ExpW-1:0] exposure;
    logic            write;
    logic [LatW-1:0] latency;
    logic            update;
  } exposure_report_t;

  typedef struct packed {
    logic               is_reg;
    logic [CfgIdxW-1:0] reg_idx;
    logic [CfgW-1:0]    reg_data;
    logic [MeanW-1:0]   mean;
    logic               known;
    exposure_report_t   want;
  } stim_row_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i  = '0;
  logic [CfgW-1:0]    cfg_wdata_i  = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic [MeanW-1:0]   frame_mean_i = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic [ExpW-1:0]    exposure_out_o;
  logic               exposure_write_o;
  logic [LatW-1:0]    latency_avg_o;
  logic               latency_update_o;

  // register copies, reset values
  logic                    mode_q     = 1'b0;
  logic [MeanW-1:0]        target_q   = MeanW'(100);
  logic signed [GainW-1:0] kp_q       = GainW'(1);
  logic signed [GainW-1:0] kd_q       = '0;
  logic [ExpW-1:0]         exp_low_q  = '0;
  logic [ExpW-1:0]         exp_high_q = ExpW'(10000);

  // loop and test state
  phase_e             cur_phase    = PH_INIT;
  logic [ExpW-1:0]    acc_exposure = ExposureReset;
  logic [MeanW-1:0]   prev_mean    = '0;
  logic [SettleW-1:0] settle       = '0;
  logic [RoundW-1:0]  rounds       = '0;
  logic [CountW-1:0]  meas_cnt     = '0;
  logic [MeanW-1:0]   dark_ref     = '0;
  logic [MeanW-1:0]   bright_ref   = '0;
  logic [LatW-1:0]    lat_avg      = '0;

  exposure_report_t exposure_reports_q [$];
  stim_row_t        directed_rows [NumDirected];
  int unsigned      fault_count = 0;
  int unsigned      idle_cycles = 0;
  int unsigned      lag_frames  = 0;
  bit               tx_burst    = 1'b0;
  bit               hold_rx_req = 1'b0;

  auto_exposure_pd_latency_test_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .frame_mean_i     (frame_mean_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .exposure_out_o   (exposure_out_o),
    .exposure_write_o (exposure_write_o),
    .latency_avg_o    (latency_avg_o),
    .latency_update_o (latency_update_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic stim_row_t reg_row(input logic [CfgIdxW-1:0] idx,
                                        input logic [CfgW-1:0] data);
    stim_row_t r;
    r          = '0;
    r.is_reg   = 1'b1;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  function automatic stim_row_t frame_row(input logic [MeanW-1:0] mean);
    stim_row_t r;
    r      = '0;
    r.mean = mean;
    return r;
  endfunction

  function automatic stim_row_t known_row(input logic [MeanW-1:0] mean,
                                          input logic [ExpW-1:0] exposure,
                                          input logic write,
                                          input logic [LatW-1:0] latency,
                                          input logic update);
    stim_row_t r;
    r                = '0;
    r.mean           = mean;
    r.known          = 1'b1;
    r.want.exposure  = exposure;
    r.want.write     = write;
    r.want.latency   = latency;
    r.want.update    = update;
    return r;
  endfunction

  // within ten percent: 10 * |mean - level| < level + 10
  function automatic bit within_tenth(input logic [MeanW-1:0] mean,
                                      input logic [MeanW-1:0] level);
    int unsigned gap_abs;
    gap_abs = (mean > level) ? int'(mean) - int'(level) : int'(level) - int'(mean);
    return (10 * gap_abs) < (int'(level) + 10);
  endfunction

  function automatic exposure_report_t advance_exposure_loop(input logic [MeanW-1:0] mean);
    exposure_report_t r;
    int               p_term;
    int               d_term;
    logic [MeanW-1:0] level;
    logic [63:0]      num;
    bit               is_dark;
    r = '0;
    if (!mode_q) begin
      if (prev_mean == '0) prev_mean = mean;
      p_term       = (int'(target_q) - int'(mean)) * int'(kp_q);
      d_term       = (int'(mean) - int'(prev_mean)) * int'(kd_q);
      acc_exposure = acc_exposure + ExpW'(p_term) + ExpW'(d_term);
      r.exposure   = acc_exposure;
      r.write      = 1'b1;
      prev_mean    = mean;
    end else begin
      case (cur_phase)
        PH_INIT_DARK: begin
          if (mean < dark_ref) begin
            dark_ref = mean;
            settle   = '0;
          end else begin
            settle++;
          end
          if (settle == QuietFrames) begin
            settle     = '0;
            bright_ref = mean;
            r.exposure = exp_high_q;
            r.write    = 1'b1;
            cur_phase  = PH_INIT_BRIGHT;
          end
        end
        PH_INIT_BRIGHT: begin
          if (mean > bright_ref) begin
            bright_ref = mean;
            settle     = '0;
          end else begin
            settle++;
          end
          if (settle == QuietFrames) begin
            settle     = '0;
            r.exposure = exp_low_q;
            r.write    = 1'b1;
            rounds++;
            if ({1'b0, rounds} < InitRounds) begin
              dark_ref  = mean;
              cur_phase = PH_INIT_DARK;
            end else begin
              cur_phase = PH_MEAS_DARK;
            end
          end
        end
        PH_MEAS_DARK, PH_MEAS_BRIGHT: begin
          is_dark = (cur_phase == PH_MEAS_DARK);
          level   = is_dark ? dark_ref : bright_ref;
          if (within_tenth(mean, level)) begin
            // running average in q5.8, truncating divide
            num     = 64'(meas_cnt) * 64'(lat_avg) + (64'(settle) << 8);
            lat_avg = LatW'(num / (64'(meas_cnt) + 64'd1));
            if (meas_cnt != '1) meas_cnt++;
            r.update   = 1'b1;
            settle     = '0;
            r.exposure = is_dark ? exp_high_q : exp_low_q;
            r.write    = 1'b1;
            cur_phase  = is_dark ? PH_MEAS_BRIGHT : PH_MEAS_DARK;
          end else begin
            settle++;
          end
        end
        default: begin
          rounds     = '0;
          settle     = '0;
          meas_cnt   = '0;
          dark_ref   = mean;
          bright_ref = mean;
          r.exposure = exp_high_q;
          r.write    = 1'b1;
          cur_phase  = PH_INIT_BRIGHT;
        end
      endcase
      if (settle > TimeoutFrames) cur_phase = PH_INIT;
    end
    r.latency = lat_avg;
    return r;
  endfunction

  // register value with a bias toward the extremes, sometimes with junk above the field
  function automatic logic [CfgW-1:0] pick_value(input int unsigned width);
    logic [CfgW-1:0] mask;
    logic [CfgW-1:0] v;
    mask = CfgW'((64'd1 << width) - 64'd1);
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = mask;
      2: v = (mask >> 1) + CfgW'(1);
      3: v = mask >> 1;
      default: v = CfgW'($urandom) & mask;
    endcase
    if (width < CfgW && $urandom_range(0, 3) == 0) v = v | (CfgW'($urandom) << width);
    return v;
  endfunction

  // sensor stand-in: mean follows the exposure last written, with a short lag
  function automatic logic [MeanW-1:0] scene_mean(input int unsigned dark_lvl,
                                                  input int unsigned bright_lvl);
    int unsigned level;
    int unsigned spread;
    int          v;
    if (lag_frames > 0) begin
      lag_frames--;
      level = (dark_lvl + bright_lvl) / 2;
    end else if (cur_phase == PH_INIT_BRIGHT || cur_phase == PH_MEAS_BRIGHT) begin
      level = bright_lvl;
    end else begin
      level = dark_lvl;
    end
    if ($urandom_range(0, 19) == 0) return MeanW'($urandom_range(0, 32767));
    spread = (level + 10) / 10 + 1;
    v      = int'(level) + int'($urandom_range(0, 2 * spread)) - int'(spread);
    if (v < 0) v = 0;
    if (v > 32767) v = 32767;
    return MeanW'(v);
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      RegTestMode: mode_q     = data[0];
      RegTarget:   target_q   = data[MeanW-1:0];
      RegPropGain: kp_q       = data[GainW-1:0];
      RegDiffGain: kd_q       = data[GainW-1:0];
      RegExpLow:   exp_low_q  = data;
      RegExpHigh:  exp_high_q = data;
      default: ;
    endcase
  endtask

  task automatic wait_block_idle();
    in_valid_i <= 1'b0;
    while (exposure_reports_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_frame(input logic [MeanW-1:0] mean, input bit known,
                            input exposure_report_t want);
    exposure_report_t predicted;
    int unsigned      gap;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    frame_mean_i <= mean;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = advance_exposure_loop(mean);
    exposure_reports_q.push_back(known ? want : predicted);
    // new exposure on the sensor: a few transition frames, now and then long enough to time out
    if (mode_q && predicted.write) begin
      lag_frames = ($urandom_range(0, 19) == 0) ? 24 : $urandom_range(0, 5);
    end
  endtask

  // frame source
  initial begin
    int unsigned      seg_len;
    int unsigned      dark_lvl;
    int unsigned      bright_lvl;
    int unsigned      frames_sent;
    bit               test_seg;
    logic [MeanW-1:0] mean;
    directed_rows = '{
      known_row(15'd0,     32'd10100,     1'b1, 13'd0, 1'b0),
      known_row(15'd32767, 32'hFFFF_A7D9, 1'b1, 13'd0, 1'b0),
      known_row(15'd100,   32'hFFFF_A7D9, 1'b1, 13'd0, 1'b0),
      reg_row(RegTarget,   32'd32767),
      reg_row(RegPropGain, 32'h0000_7FFF),
      reg_row(RegDiffGain, 32'h0000_8000),
      frame_row(15'd0),
      frame_row(15'd32767),
      reg_row(RegTarget,   32'd0),
      reg_row(RegPropGain, 32'h0000_8000),
      reg_row(RegDiffGain, 32'h0000_7FFF),
      frame_row(15'd32767),
      frame_row(15'd0),
      reg_row(RegExpLow,   32'd0),
      reg_row(RegExpHigh,  32'hFFFF_FFFF),
      reg_row(RegTestMode, 32'd1),
      // init: seed both extremes, then two learning rounds
      known_row(15'd500,   32'hFFFF_FFFF, 1'b1, 13'd0, 1'b0),
      known_row(15'd900,   32'd0,         1'b0, 13'd0, 1'b0),
      known_row(15'd900,   32'd0,         1'b0, 13'd0, 1'b0),
      known_row(15'd900,   32'd0,         1'b0, 13'd0, 1'b0),
      known_row(15'd900,   32'd0,         1'b1, 13'd0, 1'b0),
      known_row(15'd100,   32'd0,         1'b0, 13'd0, 1'b0),
      known_row(15'd100,   32'd0,         1'b0, 13'd0, 1'b0),
      known_row(15'd100,   32'd0,         1'b0, 13'd0, 1'b0),
      known_row(15'd100,   32'hFFFF_FFFF, 1'b1, 13'd0, 1'b0),
      known_row(15'd800,   32'd0,         1'b0, 13'd0, 1'b0),
      known_row(15'd800,   32'd0,         1'b0, 13'd0, 1'b0),
      known_row(15'd800,   32'd0,         1'b0, 13'd0, 1'b0),
      known_row(15'd800,   32'd0,         1'b1, 13'd0, 1'b0),
      // measuring: dark 100, bright 800
      known_row(15'd400,   32'd0,         1'b0, 13'd0, 1'b0),
      known_row(15'd105,   32'hFFFF_FFFF, 1'b1, 13'd256, 1'b1),
      known_row(15'd800,   32'd0,         1'b1, 13'd128, 1'b1),
      // just outside, then just inside the ten percent band
      known_row(15'd111,   32'd0,         1'b0, 13'd128, 1'b0),
      known_row(15'd110,   32'hFFFF_FFFF, 1'b1, 13'd170, 1'b1)
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_reg) begin
        if (!cfg_we_i) wait_block_idle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        cfg_we_i <= 1'b0;
        send_frame(directed_rows[i].mean, directed_rows[i].known, directed_rows[i].want);
      end
    end

    frames_sent = 0;
    while (frames_sent < RandomFrames) begin
      test_seg = $urandom_range(0, 99) < 65;
      seg_len  = test_seg ? $urandom_range(60, 160) : $urandom_range(15, 50);
      wait_block_idle();
      write_reg(RegTestMode, (CfgW'($urandom) & ~CfgW'(1)) | CfgW'(test_seg));
      write_reg(RegTarget,   pick_value(MeanW));
      write_reg(RegPropGain, pick_value(GainW));
      write_reg(RegDiffGain, pick_value(GainW));
      write_reg(RegExpLow,   pick_value(ExpW));
      write_reg(RegExpHigh,  pick_value(ExpW));
      cfg_we_i   <= 1'b0;
      tx_burst   = $urandom_range(0, 3) == 0;
      dark_lvl   = $urandom_range(0, 3000);
      bright_lvl = $urandom_range(6000, 32767);
      lag_frames = 0;
      for (int n = 0; n < seg_len; n++) begin
        // long output stall mid-segment so the block backs up into the input
        if (frames_sent >= 300 && n == 5) hold_rx_req = 1'b1;
        if (test_seg) begin
          mean = scene_mean(dark_lvl, bright_lvl);
        end else begin
          mean = ($urandom_range(0, 9) == 0) ? '0 : MeanW'($urandom_range(0, 32767));
        end
        send_frame(mean, 1'b0, '0);
        frames_sent++;
      end
    end

    wait_block_idle();
    if (fault_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // result sink and checker
  initial begin
    exposure_report_t want;
    int unsigned      stall;
    bit               rx_burst;
    bit               hold_taken;
    rx_burst   = 1'b0;
    hold_taken = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_rx_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready_i <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
      end else begin
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        stall = rx_burst ? 0 : $urandom_range(0, 9);
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (exposure_reports_q.size() == 0) begin
        $error("result with no frame pending: exposure_out %0h", exposure_out_o);
        fault_count++;
      end else begin
        want = exposure_reports_q.pop_front();
        if (exposure_out_o !== want.exposure) begin
          $error("exposure_out: expected %0h, got %0h", want.exposure, exposure_out_o);
          fault_count++;
        end
        if (exposure_write_o !== want.write) begin
          $error("exposure_write: expected %0d, got %0d", want.write, exposure_write_o);
          fault_count++;
        end
        if (latency_avg_o !== want.latency) begin
          $error("latency_avg: expected %0d, got %0d", want.latency, latency_avg_o);
          fault_count++;
        end
        if (latency_update_o !== want.update) begin
          $error("latency_update: expected %0d, got %0d", want.update, latency_update_o);
          fault_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
